/* design/ssr_pkg.sv */
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types, constants and the digit decode table for the seven-segment
// scan reader.
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int SEG_CHANNELS   = 6;
    localparam int DIGITS         = 4;
    localparam int SAMPLE_W       = 8;
    localparam int LINES_W        = 4;
    localparam int VALUE_W        = 11;
    localparam int COUNT_W        = 3;
    localparam int DIGIT_IDX_W    = 2;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 16;

    localparam logic [SAMPLE_W-1:0]     THRESHOLD_RESET = 8'd128;
    localparam logic [SEG_CHANNELS-1:0] LEAD_MASK       = 6'h28;
    localparam logic [COUNT_W-1:0]      LAST_CHANNEL    = 3'd5;

    // Item kind carried in tuser
    localparam logic OP_STROBE = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Single active multiplex line patterns
    localparam logic [LINES_W-1:0] LINE_0 = 4'b0001;
    localparam logic [LINES_W-1:0] LINE_1 = 4'b0010;
    localparam logic [LINES_W-1:0] LINE_2 = 4'b0100;
    localparam logic [LINES_W-1:0] LINE_3 = 4'b1000;

    typedef logic [SEG_CHANNELS-1:0] seg_pattern_t;

    typedef struct packed {
        logic                op;
        logic [LINES_W-1:0]  strobe_lines;
        logic [SAMPLE_W-1:0] sample;
    } ssr_item_t;

    typedef struct packed {
        logic               scan_active;
        logic               frame_rejected;
        logic               value_updated;
        logic [VALUE_W-1:0] display_value;
    } ssr_result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
    } digit_dec_t;

    // Map a segment pattern to its digit; ok is low for unknown patterns
    function automatic digit_dec_t decode_pattern(input seg_pattern_t p);
        digit_dec_t d;
        d.ok = 1'b1;
        case (p)
            6'h3D:   d.digit = 4'd0;
            6'h28:   d.digit = 4'd1;
            6'h1B:   d.digit = 4'd2;
            6'h3A:   d.digit = 4'd3;
            6'h2E:   d.digit = 4'd4;
            6'h36:   d.digit = 4'd5;
            6'h37:   d.digit = 4'd6;
            6'h38:   d.digit = 4'd7;
            6'h3F:   d.digit = 4'd8;
            6'h3E:   d.digit = 4'd9;
            default:
            begin
                d.ok    = 1'b0;
                d.digit = 4'd0;
            end
        endcase
        return d;
    endfunction

endpackage

/* design/ssr_in_stage.sv */
// ----------------------------------------------------------------------------
// ssr_in_stage
// Input register: captures one beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module ssr_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [3:0] strobe_lines, [11:4] sample, rest zero
    input  logic              s_tuser,   // op
    input  logic              advance,
    output logic              item_valid,
    output ssr_pkg::ssr_item_t item
);
    import ssr_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    ssr_item_t item_reg;

    // Accept when empty or when the held beat moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture payload of an accepted beat
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op           <= s_tuser;
            item_reg.strobe_lines <= s_tdata[LINES_W-1:0];
            item_reg.sample       <= s_tdata[LINES_W+SAMPLE_W-1:LINES_W];
        end
    end

endmodule

/* design/ssr_core.sv */
// ----------------------------------------------------------------------------
// ssr_core
// Scan state, segment compare, digit decode and value update.
// ----------------------------------------------------------------------------
module ssr_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data,
    input  logic                  advance,
    input  ssr_pkg::ssr_item_t    item,
    output ssr_pkg::ssr_result_t  result
);
    import ssr_pkg::*;

    logic [SAMPLE_W-1:0]    threshold_reg;
    logic                   busy_reg, busy_next;
    logic [DIGIT_IDX_W-1:0] digit_reg, digit_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    seg_pattern_t           pat_reg  [DIGITS];
    seg_pattern_t           pat_next [DIGITS];
    logic [VALUE_W-1:0]     held_reg, held_next;
    logic                   updated;
    logic                   rejected;
    logic                   lit;
    digit_dec_t             dec [DIGITS];
    logic [VALUE_W-1:0]     frame_value;
    logic                   frame_ok;

    assign lit = item.sample < threshold_reg;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (cfg_wr_en)
            threshold_reg <= cfg_wr_data;
    end

    // Update patterns for the scanned digit and channel
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            pat_next[d] = pat_reg[d];
            if (advance && item.op == OP_SAMPLE && busy_reg &&
                digit_reg == DIGIT_IDX_W'(d))
            begin
                for (int b = 0; b < SEG_CHANNELS; b++)
                begin
                    if (count_reg == COUNT_W'(b))
                        pat_next[d][b] = lit;
                end
            end
        end
    end

    // Decode the frame from the updated patterns
    always_comb
    begin
        dec[0] = decode_pattern(pat_next[0] & LEAD_MASK);
        for (int d = 1; d < DIGITS; d++)
            dec[d] = decode_pattern(pat_next[d]);
        frame_ok    = dec[1].ok && dec[2].ok && dec[3].ok;
        frame_value = (dec[0].ok ? VALUE_W'(dec[0].digit) * VALUE_W'(1000) : '0)
                    + VALUE_W'(dec[3].digit) * VALUE_W'(100)
                    + VALUE_W'(dec[1].digit) * VALUE_W'(10)
                    + VALUE_W'(dec[2].digit);
    end

    // Scan control
    always_comb
    begin
        busy_next  = busy_reg;
        digit_next = digit_reg;
        count_next = count_reg;
        held_next  = held_reg;
        updated    = 1'b0;
        rejected   = 1'b0;
        if (advance)
        begin
            if (item.op == OP_STROBE)
            begin
                if (!busy_reg)
                begin
                    case (item.strobe_lines)
                        LINE_0:
                        begin
                            digit_next = 2'd0;
                            count_next = '0;
                            busy_next  = 1'b1;
                        end
                        LINE_1:
                        begin
                            digit_next = 2'd1;
                            count_next = '0;
                            busy_next  = 1'b1;
                        end
                        LINE_2:
                        begin
                            digit_next = 2'd2;
                            count_next = '0;
                            busy_next  = 1'b1;
                        end
                        LINE_3:
                        begin
                            digit_next = 2'd3;
                            count_next = '0;
                            busy_next  = 1'b1;
                        end
                        default:
                        begin
                            busy_next = busy_reg;
                        end
                    endcase
                end
            end
            else if (busy_reg)
            begin
                if (count_reg >= LAST_CHANNEL)
                begin
                    busy_next  = 1'b0;
                    count_next = '0;
                    if (frame_ok)
                    begin
                        held_next = frame_value;
                        updated   = 1'b1;
                    end
                    else
                    begin
                        rejected = 1'b1;
                    end
                end
                else
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            digit_reg <= '0;
            count_reg <= '0;
            held_reg  <= '0;
            for (int d = 0; d < DIGITS; d++)
                pat_reg[d] <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            digit_reg <= digit_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            for (int d = 0; d < DIGITS; d++)
                pat_reg[d] <= pat_next[d];
        end
    end

    assign result.display_value  = held_next;
    assign result.value_updated  = updated;
    assign result.frame_rejected = rejected;
    assign result.scan_active    = busy_next;

endmodule

/* design/ssr_out_stage.sv */
// ----------------------------------------------------------------------------
// ssr_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module ssr_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  ssr_pkg::ssr_result_t result,
    output logic                 advance,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata   // [10:0] display_value, [11] value_updated,
                                           // [12] frame_rejected, [13] scan_active
);
    import ssr_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    ssr_result_t result_reg;

    // Move an item when the result slot is free or being drained
    assign advance  = item_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(ssr_result_t)){1'b0}}, result_reg};

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result;
    end

endmodule

/* design/seven_segment_scan_reader_unit.sv */
// ----------------------------------------------------------------------------
// seven_segment_scan_reader_unit
// Reads a multiplexed four-digit seven-segment display from strobe and
// segment sample beats and reports the decoded reading.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_*      in         tuser op, tdata {sample, strobe_lines}
//  m_*      out        tdata {scan_active, frame_rejected, value_updated, value}
//  cfg_*    in         segment_threshold write
//
//  One beat per cycle sustained while the output is not stalled; each beat
//  goes through the input register, then compare/decode into the result
//  register.
//  Reset is asynchronous active low; it clears the scan state, the held value
//  and sets the threshold to 128.
//  A stalled output holds its result; the input register still takes one
//  beat while the result waits.
// ----------------------------------------------------------------------------
module seven_segment_scan_reader_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [3:0] strobe_lines, [11:4] sample, rest zero
    input  logic        s_tuser,     // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [10:0] display_value, [11] value_updated,
                                     // [12] frame_rejected, [13] scan_active, rest zero
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data  // segment_threshold
);
    import ssr_pkg::*;

    logic        advance;
    logic        item_valid;
    ssr_item_t   item;
    ssr_result_t result;

    ssr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ssr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .item        (item),
        .result      (result)
    );

    ssr_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives strobe and segment-sample beats into the seven-segment scan reader,
// predicts every result beat from a local model of the scan and decode
// behavior, and checks the results in order under random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
    import ssr_pkg::*;

    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DRAIN_LIMIT      = 50000;
    localparam int RANDOM_BEATS     = 1100;
    localparam int QUIET_BEATS      = 250;

    // Segment pattern of each digit 0..9, index 0 first
    localparam logic [0:9][SEG_CHANNELS-1:0] SEG_OF_DIGIT = {
        6'h3D, 6'h28, 6'h1B, 6'h3A, 6'h2E, 6'h36, 6'h37, 6'h38, 6'h3F, 6'h3E
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;      // [3:0] strobe_lines, [11:4] sample, rest zero
    logic        s_tuser;      // [0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // [10:0] display_value, [11] value_updated,
                               // [12] frame_rejected, [13] scan_active
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    // Reader model state
    logic                 exp_busy;
    logic [1:0]           exp_digit;
    logic [COUNT_W-1:0]   exp_chan;
    seg_pattern_t         exp_pat [DIGITS];
    logic [VALUE_W-1:0]   exp_value;
    logic [SAMPLE_W-1:0]  exp_thr;

    ssr_result_t pending_readings [$];

    // Stimulus controls and bookkeeping
    logic [SAMPLE_W-1:0] level_thr;
    int  tx_gap_pct;
    int  rx_stall_pct;
    bit  long_hold_req;
    int  beats_sent;
    int  mismatches;
    int  frames_decoded;
    int  frames_rejected;
    int  thr_writes;

    seven_segment_scan_reader_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #1_500_000;
        $display("seven_segment_scan_reader_unit verification failed");
        $finish;
    end

    // Look up a digit by its segment pattern; -1 when not in the table
    function automatic int digit_of(input seg_pattern_t p);
        int found;
        found = -1;
        for (int k = 0; k < 10; k++)
            if (SEG_OF_DIGIT[k] == p)
                found = k;
        return found;
    endfunction

    // Advance the reader model by one beat and return the reading it reports
    function automatic ssr_result_t advance_reader(input logic op,
                                                   input logic [LINES_W-1:0] lines,
                                                   input logic [SAMPLE_W-1:0] level);
        ssr_result_t r;
        int v0, v1, v2, v3;
        r = '0;
        if (op == OP_STROBE)
        begin
            if (!exp_busy)
            begin
                case (lines)
                    LINE_0:
                    begin
                        exp_digit = 2'd0;
                        exp_busy  = 1'b1;
                    end
                    LINE_1:
                    begin
                        exp_digit = 2'd1;
                        exp_busy  = 1'b1;
                    end
                    LINE_2:
                    begin
                        exp_digit = 2'd2;
                        exp_busy  = 1'b1;
                    end
                    LINE_3:
                    begin
                        exp_digit = 2'd3;
                        exp_busy  = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                exp_chan = '0;
            end
        end
        else if (exp_busy)
        begin
            exp_pat[exp_digit][exp_chan] = (level < exp_thr);
            if (exp_chan == LAST_CHANNEL)
            begin
                // Frame complete: decode all four digits
                exp_busy = 1'b0;
                exp_chan = '0;
                v0 = digit_of(exp_pat[0] & LEAD_MASK);
                v1 = digit_of(exp_pat[1]);
                v2 = digit_of(exp_pat[2]);
                v3 = digit_of(exp_pat[3]);
                if (v1 >= 0 && v2 >= 0 && v3 >= 0)
                begin
                    if (v0 < 0)
                        v0 = 0;
                    exp_value = VALUE_W'(v0 * 1000 + v3 * 100 + v1 * 10 + v2);
                    r.value_updated = 1'b1;
                end
                else
                begin
                    r.frame_rejected = 1'b1;
                end
            end
            else
            begin
                exp_chan = exp_chan + 1'b1;
            end
        end
        r.display_value = exp_value;
        r.scan_active   = exp_busy;
        return r;
    endfunction

    // Predict on accepted input beats, check accepted result beats
    always @(posedge clk)
    begin : score
        ssr_result_t want;
        ssr_result_t got;
        if (rst_n)
        begin
            if (cfg_wr_en)
                exp_thr = cfg_wr_data;
            if (s_tvalid && s_tready)
                pending_readings.push_back(advance_reader(s_tuser, s_tdata[3:0],
                                                          s_tdata[11:4]));
            if (m_tvalid && m_tready)
            begin
                got = ssr_result_t'(m_tdata[13:0]);
                frames_decoded  += got.value_updated;
                frames_rejected += got.frame_rejected;
                if (pending_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected: %h", $time, m_tdata);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.display_value  !== want.display_value  ||
                        got.value_updated  !== want.value_updated  ||
                        got.frame_rejected !== want.frame_rejected ||
                        got.scan_active    !== want.scan_active)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch value %0d/%0d updated %b/%b ",
                                      "rejected %b/%b active %b/%b (expected/actual)"},
                                     $time, want.display_value, got.display_value,
                                     want.value_updated, got.value_updated,
                                     want.frame_rejected, got.frame_rejected,
                                     want.scan_active, got.scan_active);
                    end
                end
            end
        end
    end

    // Result side: random stall bursts and the long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                m_tready = 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(14, 0)) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // Offer one beat, with an optional gap first; returns at the falling edge
    // after the accept, leaving tvalid high
    task automatic send_beat(input logic op, input logic [LINES_W-1:0] lines,
                             input logic [SAMPLE_W-1:0] level);
        int gap;
        gap = 0;
        if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct)
            gap = $urandom_range(15, 1);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = op;
        s_tdata  = {4'b0000, level, lines};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        beats_sent++;
    endtask

    // Hold the input and wait until every expected reading has arrived
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid = 1'b0;
        while (pending_readings.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [SAMPLE_W-1:0] value);
        wait_drained();
        cfg_wr_data = value;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        level_thr   = value;
        thr_writes++;
    endtask

    // Sample level that reads as lit or dark under the current threshold
    function automatic logic [SAMPLE_W-1:0] level_for(input bit lit, input bit extreme);
        if (lit && level_thr != 0)
        begin
            if (extreme)
                return '0;
            if ($urandom_range(3) == 0)
                return level_thr - 1'b1;
            return SAMPLE_W'($urandom_range(level_thr - 1, 0));
        end
        if (extreme)
            return '1;
        if ($urandom_range(3) == 0)
            return level_thr;
        return SAMPLE_W'($urandom_range(255, level_thr));
    endfunction

    function automatic seg_pattern_t pick_pattern();
        if ($urandom_range(99) < 80)
            return SEG_OF_DIGIT[$urandom_range(9)];
        return seg_pattern_t'($urandom_range(63));
    endfunction

    // Strobe one digit line, then feed its six segment samples; optionally
    // slip a strobe in mid-scan, which the block must ignore
    task automatic scan_digit(input int d, input seg_pattern_t pat, input bit extreme,
                              input bit poke);
        send_beat(OP_STROBE, LINES_W'(1 << d), SAMPLE_W'($urandom_range(255)));
        for (int c = 0; c < SEG_CHANNELS; c++)
        begin
            if (poke && c == 3)
                send_beat(OP_STROBE, LINES_W'($urandom_range(15)),
                          SAMPLE_W'($urandom_range(255)));
            send_beat(OP_SAMPLE, LINES_W'($urandom_range(15)), level_for(pat[c], extreme));
        end
    endtask

    task automatic test_directed();
        // Ignored beats: sample while idle, strobes with no or several lines
        send_beat(OP_SAMPLE, 4'b0000, 8'd0);
        send_beat(OP_STROBE, 4'b0000, 8'd255);
        send_beat(OP_STROBE, 4'b1111, 8'd0);
        send_beat(OP_STROBE, 4'b0110, 8'd255);
        // Digits one by one; frames reject until digits 1 to 3 all decode,
        // and the blank leading digit then counts as zero
        scan_digit(1, SEG_OF_DIGIT[1], 1'b1, 1'b1);
        scan_digit(2, SEG_OF_DIGIT[2], 1'b1, 1'b0);
        scan_digit(3, SEG_OF_DIGIT[3], 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_threshold_sweep();
        logic [SAMPLE_W-1:0] levels [5];
        levels = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128};
        // Full leading digit masks down to a one
        scan_digit(0, SEG_OF_DIGIT[8], 1'b1, 1'b0);
        foreach (levels[i])
        begin
            write_threshold(levels[i]);
            for (int f = 0; f < 4; f++)
                scan_digit($urandom_range(3), pick_pattern(), 1'b0, 1'b0);
            scan_digit($urandom_range(3), pick_pattern(), 1'b1, 1'b0);
        end
        wait_drained();
    endtask

    task automatic run_random_frames(input int count, input bit retune);
        int stop_at;
        int next_tune;
        int r;
        stop_at   = beats_sent + count;
        next_tune = beats_sent + 150;
        while (beats_sent < stop_at)
        begin
            if (retune && beats_sent >= next_tune)
            begin
                r = $urandom_range(9);
                write_threshold(r == 0 ? 8'd0 : r == 1 ? 8'd255 :
                                SAMPLE_W'($urandom_range(255)));
                r = $urandom_range(2);
                tx_gap_pct   = r == 0 ? 0 : r == 1 ? 10 : 30;
                r = $urandom_range(2);
                rx_stall_pct = r == 0 ? 0 : r == 1 ? 10 : 30;
                next_tune = beats_sent + 150;
            end
            r = $urandom_range(99);
            if (r < 72)
            begin
                scan_digit($urandom_range(3), pick_pattern(), 1'b0, $urandom_range(99) < 6);
            end
            else if (r < 82)
            begin
                // Broken scan: stop early and let later beats run into it
                send_beat(OP_STROBE, LINES_W'(1 << $urandom_range(3)),
                          SAMPLE_W'($urandom_range(255)));
                repeat ($urandom_range(5))
                    send_beat(OP_SAMPLE, LINES_W'($urandom_range(15)),
                              level_for($urandom_range(1), 1'b0));
            end
            else
            begin
                repeat ($urandom_range(3, 1))
                    send_beat(1'($urandom_range(1)), LINES_W'($urandom_range(15)),
                              SAMPLE_W'($urandom_range(255)));
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_gap_pct    = 0;
        rx_stall_pct  = 0;
        long_hold_req = 1'b1;
        for (int f = 0; f < 6; f++)
            scan_digit($urandom_range(3), pick_pattern(), 1'b0, 1'b0);
        // Pause until every reading is back
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_STROBE;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        exp_busy      = 1'b0;
        exp_digit     = '0;
        exp_chan      = '0;
        exp_value     = '0;
        exp_thr       = THRESHOLD_RESET;
        foreach (exp_pat[i])
            exp_pat[i] = '0;
        level_thr     = THRESHOLD_RESET;
        tx_gap_pct    = 0;
        rx_stall_pct  = 0;
        long_hold_req = 1'b0;
        beats_sent      = 0;
        mismatches      = 0;
        frames_decoded  = 0;
        frames_rejected = 0;
        thr_writes      = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        test_threshold_sweep();
        run_random_frames(RANDOM_BEATS, 1'b1);
        test_backpressure();
        write_threshold(SAMPLE_W'($urandom_range(255)));
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        run_random_frames(QUIET_BEATS, 1'b0);

        // Count readings that never arrived
        wait_drained();
        repeat (8) @(negedge clk);
        mismatches += pending_readings.size();

        $display("Covered %0d beats over %0d threshold settings: %0d frames decoded, %0d rejected,",
                 beats_sent, thr_writes + 1, frames_decoded, frames_rejected);
        $display("with input gaps, output stalls and a %0d-cycle output hold-off; %0d mismatches.",
                 LONG_HOLD_CYCLES, mismatches);
        if (mismatches == 0)
            $display("seven_segment_scan_reader_unit verification clean");
        else
            $display("seven_segment_scan_reader_unit verification failed");
        $finish;
    end

endmodule
